@@ hw/rtl/lfu_pkg.sv @@
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int WORD_W          = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
    localparam logic [WORD_W-1:0] COUNT_MAX = '1;
    localparam logic [WORD_W-1:0] COUNT_ONE = WORD_W'(1);
    localparam logic [WORD_W-1:0] MISS_DATA = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] read_value;
        logic                     evicted;
        logic signed [WORD_W-1:0] evicted_key;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/lfu_if.sv @@
`default_nettype none

interface lfu_item_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic signed [lfu_pkg::WORD_W-1:0] key;
    logic signed [lfu_pkg::WORD_W-1:0] value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface lfu_result_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic signed [lfu_pkg::WORD_W-1:0] read_value;
    logic                             evicted;
    logic signed [lfu_pkg::WORD_W-1:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lfu_ram.sv @@
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = lfu_pkg::WORD_W,
    parameter int DEPTH = lfu_pkg::ENTRIES_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lfu_seq.sv @@
`default_nettype none

module lfu_seq #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire lfu_pkg::item_t             item,
    input  wire logic [lfu_pkg::CAP_W-1:0]  capacity,
    output logic                            idle,
    output logic                            done_valid,
    input  wire logic                       done_ready,
    output lfu_pkg::result_t                result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int CW = (FW > lfu_pkg::CAP_W) ? FW : lfu_pkg::CAP_W;
    localparam int WW = lfu_pkg::WORD_W;
    localparam logic [FW-1:0] LAST    = FW'(ENTRIES);
    localparam logic [CW-1:0] ENT_CAP = CW'(ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [FW-1:0]      cnt_reg, cnt_next;
    logic               p_vld_reg, p_vld_next;
    logic [IW-1:0]      p_idx_reg, p_idx_next;

    logic               op_reg, op_next;
    logic [WW-1:0]      key_reg, key_next;
    logic [WW-1:0]      val_reg, val_next;

    logic               found_reg, found_next;
    logic [IW-1:0]      s_idx_reg, s_idx_next;
    logic [IW-1:0]      s_rank_reg, s_rank_next;
    logic [WW-1:0]      s_count_reg, s_count_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               vf_reg, vf_next;
    logic [IW-1:0]      v_idx_reg, v_idx_next;
    logic [IW-1:0]      v_rank_reg, v_rank_next;
    logic [WW-1:0]      v_count_reg, v_count_next;
    logic [WW-1:0]      v_key_reg, v_key_next;
    logic               ff_reg, ff_next;
    logic [IW-1:0]      f_idx_reg, f_idx_next;

    logic [IW-1:0]      tgt_reg, tgt_next;
    logic               touch_reg, touch_next;
    logic [IW-1:0]      rr_reg, rr_next;
    logic               ev_reg, ev_next;

    logic [WW-1:0]      key_rd, count_rd, data_rd;
    logic [IW-1:0]      rank_rd;

    logic               scan_re, rank_re, rank_we, key_we, data_we, count_we, data_re;
    logic [IW-1:0]      scan_addr, rank_wdata;
    logic [WW-1:0]      count_wdata;

    logic               issue, cur_valid;
    logic               get_hit, put_hit, put_miss, cap_zero, do_evict;
    logic [CW-1:0]      cap_eff, cap_ext;
    logic [IW-1:0]      slot_sel, target;
    logic [IW-1:0]      rank_dec;

    lfu_ram #(.WIDTH(WW), .DEPTH(ENTRIES), .AW(IW)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(target), .wdata(key_reg),
        .re(scan_re), .raddr(scan_addr), .rdata(key_rd)
    );

    lfu_ram #(.WIDTH(WW), .DEPTH(ENTRIES), .AW(IW)) u_data_ram (
        .clk(clk), .we(data_we), .waddr(target), .wdata(val_reg),
        .re(data_re), .raddr(s_idx_reg), .rdata(data_rd)
    );

    lfu_ram #(.WIDTH(WW), .DEPTH(ENTRIES), .AW(IW)) u_count_ram (
        .clk(clk), .we(count_we), .waddr(target), .wdata(count_wdata),
        .re(scan_re), .raddr(scan_addr), .rdata(count_rd)
    );

    lfu_ram #(.WIDTH(IW), .DEPTH(ENTRIES), .AW(IW)) u_rank_ram (
        .clk(clk), .we(rank_we), .waddr(p_idx_reg), .wdata(rank_wdata),
        .re(rank_re), .raddr(scan_addr), .rdata(rank_rd)
    );

    // decision terms, from the registered scan results, opcode and capacity
    always_comb
    begin
        cap_ext  = CW'(capacity);
        cap_eff  = (cap_ext > ENT_CAP) ? ENT_CAP : cap_ext;
        cap_zero = (capacity == '0);
        get_hit  = (op_reg == lfu_pkg::OP_GET) && found_reg;
        put_hit  = (op_reg == lfu_pkg::OP_PUT) && found_reg && !cap_zero;
        put_miss = (op_reg == lfu_pkg::OP_PUT) && !found_reg && !cap_zero;
        do_evict = put_miss && vf_reg && (CW'(fill_reg) >= cap_eff);
        if (do_evict)
        begin
            slot_sel = (ff_reg && (f_idx_reg < v_idx_reg)) ? f_idx_reg : v_idx_reg;
        end
        else
        begin
            slot_sel = f_idx_reg;
        end
        target = (state_reg == S_DECIDE) ? (found_reg ? s_idx_reg : slot_sel) : tgt_reg;
    end

    assign issue     = (cnt_reg != LAST);
    assign scan_addr = cnt_reg[IW-1:0];
    assign cur_valid = valid_reg[p_idx_reg];
    assign rank_dec  = (ev_reg && (rank_rd > rr_reg)) ? (rank_rd - IW'(1)) : rank_rd;

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        cnt_next     = cnt_reg;
        p_vld_next   = 1'b0;
        p_idx_next   = p_idx_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        found_next   = found_reg;
        s_idx_next   = s_idx_reg;
        s_rank_next  = s_rank_reg;
        s_count_next = s_count_reg;
        fill_next    = fill_reg;
        vf_next      = vf_reg;
        v_idx_next   = v_idx_reg;
        v_rank_next  = v_rank_reg;
        v_count_next = v_count_reg;
        v_key_next   = v_key_reg;
        ff_next      = ff_reg;
        f_idx_next   = f_idx_reg;
        tgt_next     = tgt_reg;
        touch_next   = touch_reg;
        rr_next      = rr_reg;
        ev_next      = ev_reg;
        scan_re      = 1'b0;
        rank_re      = 1'b0;
        rank_we      = 1'b0;
        rank_wdata   = '0;
        key_we       = 1'b0;
        data_we      = 1'b0;
        data_re      = 1'b0;
        count_we     = 1'b0;
        count_wdata  = lfu_pkg::COUNT_ONE;
        idle         = 1'b0;
        done_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    op_next    = item.opcode;
                    key_next   = item.key;
                    val_next   = item.value;
                    found_next = 1'b0;
                    fill_next  = '0;
                    vf_next    = 1'b0;
                    ff_next    = 1'b0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                scan_re = issue;
                rank_re = issue;
                if (issue)
                begin
                    p_vld_next = 1'b1;
                    p_idx_next = scan_addr;
                    cnt_next   = cnt_reg + FW'(1);
                end
                if (p_vld_reg)
                begin
                    if (cur_valid)
                    begin
                        fill_next = fill_reg + FW'(1);
                        if (!found_reg && (key_rd == key_reg))
                        begin
                            found_next   = 1'b1;
                            s_idx_next   = p_idx_reg;
                            s_rank_next  = rank_rd;
                            s_count_next = count_rd;
                        end
                        if (!vf_reg || (count_rd < v_count_reg) ||
                            ((count_rd == v_count_reg) && (rank_rd > v_rank_reg)))
                        begin
                            vf_next      = 1'b1;
                            v_idx_next   = p_idx_reg;
                            v_rank_next  = rank_rd;
                            v_count_next = count_rd;
                            v_key_next   = key_rd;
                        end
                    end
                    else if (!ff_reg)
                    begin
                        ff_next    = 1'b1;
                        f_idx_next = p_idx_reg;
                    end
                    if (!issue)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                key_we      = put_miss;
                data_we     = put_hit || put_miss;
                data_re     = get_hit;
                count_we    = get_hit || put_hit || put_miss;
                count_wdata = found_reg ? ((s_count_reg == lfu_pkg::COUNT_MAX) ?
                              s_count_reg : (s_count_reg + WW'(1))) : lfu_pkg::COUNT_ONE;
                tgt_next    = target;
                touch_next  = found_reg;
                rr_next     = found_reg ? s_rank_reg : v_rank_reg;
                ev_next     = do_evict;
                if (do_evict)
                begin
                    valid_next[v_idx_reg] = 1'b0;
                end
                if (put_miss)
                begin
                    valid_next[slot_sel] = 1'b1;
                end
                cnt_next = '0;
                if (get_hit || put_hit || put_miss)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_UPDATE:
            begin
                rank_re = issue;
                if (issue)
                begin
                    p_vld_next = 1'b1;
                    p_idx_next = scan_addr;
                    cnt_next   = cnt_reg + FW'(1);
                end
                if (p_vld_reg)
                begin
                    if (p_idx_reg == tgt_reg)
                    begin
                        rank_we    = 1'b1;
                        rank_wdata = '0;
                    end
                    else if (cur_valid)
                    begin
                        rank_we = 1'b1;
                        if (touch_reg)
                        begin
                            rank_wdata = (rank_rd < rr_reg) ? (rank_rd + IW'(1)) : rank_rd;
                        end
                        else
                        begin
                            rank_wdata = rank_dec + IW'(1);
                        end
                    end
                    if (!issue)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                done_valid = 1'b1;
                if (done_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.hit         = found_reg;
        result.evicted     = ev_reg;
        result.evicted_key = ev_reg ? v_key_reg : '0;
        if (op_reg == lfu_pkg::OP_GET)
        begin
            result.read_value = found_reg ? data_rd : lfu_pkg::MISS_DATA;
        end
        else
        begin
            result.read_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            p_vld_reg <= p_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg   <= p_idx_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        found_reg   <= found_next;
        s_idx_reg   <= s_idx_next;
        s_rank_reg  <= s_rank_next;
        s_count_reg <= s_count_next;
        fill_reg    <= fill_next;
        vf_reg      <= vf_next;
        v_idx_reg   <= v_idx_next;
        v_rank_reg  <= v_rank_next;
        v_count_reg <= v_count_next;
        v_key_reg   <= v_key_next;
        ff_reg      <= ff_next;
        f_idx_reg   <= f_idx_next;
        tgt_reg     <= tgt_next;
        touch_reg   <= touch_next;
        rr_reg      <= rr_next;
        ev_reg      <= ev_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lfu_cache_replacement.sv @@
// Fully associative key-value store of ENTRIES slots with least-frequently-used
// replacement, ties going to the least recently used entry. A get returns the
// stored value and bumps its use count; a put overwrites or inserts, evicting
// one entry when the fill has reached the capacity register (clamped to
// ENTRIES; zero turns puts into no-ops). Key, value, count and recency rank sit
// in single-port-read memories, so every item first scans all slots one per
// cycle; a get miss or a put at capacity zero then finishes after that scan,
// and every item that changes state adds a second sweep that rewrites the
// recency ranks. One item is in work at a time; a finished result waits in
// the output register while the next item is taken. No clearing pass follows
// reset. Capacity is written through cfg_we / cfg_wdata; the user must write
// it only while idle, which the block itself does not enforce.
`default_nettype none

module lfu_cache_replacement #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    lfu_item_if.sink                       req,
    lfu_result_if.source                   rsp,
    input  wire logic                      cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);

    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    logic                      rsp_valid_reg, rsp_valid_next;
    lfu_pkg::result_t          rsp_reg, rsp_next;
    lfu_pkg::item_t            item;
    lfu_pkg::result_t          result;
    logic                      seq_idle, done_valid, done_ready, start;

    assign item.opcode = req.opcode;
    assign item.key    = req.key;
    assign item.value  = req.value;

    assign req.ready  = seq_idle;
    assign start      = req.valid && seq_idle;
    assign done_ready = !rsp_valid_reg || rsp.ready;

    lfu_seq #(.ENTRIES(ENTRIES)) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .capacity   (cap_reg),
        .idle       (seq_idle),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .result     (result)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (done_valid && done_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = result;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lfu_pkg::CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_reg.hit;
    assign rsp.read_value  = rsp_reg.read_value;
    assign rsp.evicted     = rsp_reg.evicted;
    assign rsp.evicted_key = rsp_reg.evicted_key;

endmodule

`default_nettype wire
